// File: design/rau_pkg.sv
// rational arithmetic unit package: widths, operation codes, micro-instruction format
// and the micro-program rom with its dispatch table
// no dependencies
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int OP_W          = 3;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int RESULT_W      = PROD_W + 1;
  localparam int MAG_W         = PROD_W;
  localparam int SHIFT_W       = $clog2(MAG_W);
  localparam int UPC_W         = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_INC, OP_DEC, OP_CMP
  } op_t;

  // multiplier operand selects
  typedef enum logic [1:0] {MA_AN, MA_AD, MA_BN} mul_a_sel_t;
  typedef enum logic [1:0] {MB_BD, MB_BN, MB_AD} mul_b_sel_t;

  // what happens to the registered product
  typedef enum logic [2:0] {
    ACC_NONE, ACC_X_LOAD, ACC_X_ADD, ACC_X_SUB, ACC_Y_LOAD
  } acc_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_GCD_INIT, ACT_GCD_STEP, ACT_GCD_FIN, ACT_DIV_LOAD_X,
    ACT_DIV_LOAD_Y, ACT_DIV_STEP, ACT_STORE_NUM, ACT_STORE_DEN, ACT_UNARY,
    ACT_COMPARE, ACT_ERROR
  } act_t;

  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_JUMP, SEQ_GCD_LOOP, SEQ_DIV_LOOP, SEQ_GZERO, SEQ_DONE
  } seq_t;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    mul_a_sel_t ma;
    mul_b_sel_t mb;
    acc_t       acc;
    act_t       act;
    seq_t       seq;
    upc_t       target;
  } uword_t;

  // micro-program addresses
  localparam upc_t UA_ADD_0  = upc_t'(0);
  localparam upc_t UA_ADD_1  = upc_t'(1);
  localparam upc_t UA_ADD_2  = upc_t'(2);
  localparam upc_t UA_ADD_3  = upc_t'(3);
  localparam upc_t UA_SUB_0  = upc_t'(4);
  localparam upc_t UA_SUB_1  = upc_t'(5);
  localparam upc_t UA_SUB_2  = upc_t'(6);
  localparam upc_t UA_SUB_3  = upc_t'(7);
  localparam upc_t UA_MUL_0  = upc_t'(8);
  localparam upc_t UA_MUL_1  = upc_t'(9);
  localparam upc_t UA_MUL_2  = upc_t'(10);
  localparam upc_t UA_DIV_0  = upc_t'(11);
  localparam upc_t UA_DIV_1  = upc_t'(12);
  localparam upc_t UA_DIV_2  = upc_t'(13);
  localparam upc_t UA_GCD    = upc_t'(14);
  localparam upc_t UA_GLOOP  = upc_t'(15);
  localparam upc_t UA_GFIN   = upc_t'(16);
  localparam upc_t UA_GCHK   = upc_t'(17);
  localparam upc_t UA_DLDX   = upc_t'(18);
  localparam upc_t UA_DLOOPX = upc_t'(19);
  localparam upc_t UA_STNUM  = upc_t'(20);
  localparam upc_t UA_DLDY   = upc_t'(21);
  localparam upc_t UA_DLOOPY = upc_t'(22);
  localparam upc_t UA_STDEN  = upc_t'(23);
  localparam upc_t UA_FIN    = upc_t'(24);
  localparam upc_t UA_ERR    = upc_t'(25);
  localparam upc_t UA_UNARY  = upc_t'(26);
  localparam upc_t UA_CMP_0  = upc_t'(27);
  localparam upc_t UA_CMP_1  = upc_t'(28);
  localparam upc_t UA_CMP_2  = upc_t'(29);
  localparam upc_t UA_CMP_3  = upc_t'(30);

  function automatic uword_t mk(mul_a_sel_t ma, mul_b_sel_t mb, acc_t acc, act_t act,
                                seq_t seq, upc_t target);
    uword_t w;
    w.ma     = ma;
    w.mb     = mb;
    w.acc    = acc;
    w.act    = act;
    w.seq    = seq;
    w.target = target;
    return w;
  endfunction

  // micro-program rom
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      UA_ADD_0:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_ADD_1:  w = mk(MA_BN, MB_AD, ACC_X_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_ADD_2:  w = mk(MA_AD, MB_BD, ACC_X_ADD,  ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_ADD_3:  w = mk(MA_AN, MB_BD, ACC_Y_LOAD, ACT_NONE,       SEQ_JUMP,     UA_GCD);
      UA_SUB_0:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_SUB_1:  w = mk(MA_BN, MB_AD, ACC_X_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_SUB_2:  w = mk(MA_AD, MB_BD, ACC_X_SUB,  ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_SUB_3:  w = mk(MA_AN, MB_BD, ACC_Y_LOAD, ACT_NONE,       SEQ_JUMP,     UA_GCD);
      UA_MUL_0:  w = mk(MA_AN, MB_BN, ACC_NONE,   ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_MUL_1:  w = mk(MA_AD, MB_BD, ACC_X_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_MUL_2:  w = mk(MA_AN, MB_BD, ACC_Y_LOAD, ACT_NONE,       SEQ_JUMP,     UA_GCD);
      UA_DIV_0:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_DIV_1:  w = mk(MA_AD, MB_BN, ACC_X_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_DIV_2:  w = mk(MA_AN, MB_BD, ACC_Y_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_GCD:    w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_GCD_INIT,   SEQ_NEXT,     UA_FIN);
      UA_GLOOP:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_GCD_STEP,   SEQ_GCD_LOOP, UA_FIN);
      UA_GFIN:   w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_GCD_FIN,    SEQ_NEXT,     UA_FIN);
      UA_GCHK:   w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_GZERO,    UA_ERR);
      UA_DLDX:   w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_DIV_LOAD_X, SEQ_NEXT,     UA_FIN);
      UA_DLOOPX: w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_DIV_STEP,   SEQ_DIV_LOOP, UA_FIN);
      UA_STNUM:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_STORE_NUM,  SEQ_NEXT,     UA_FIN);
      UA_DLDY:   w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_DIV_LOAD_Y, SEQ_NEXT,     UA_FIN);
      UA_DLOOPY: w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_DIV_STEP,   SEQ_DIV_LOOP, UA_FIN);
      UA_STDEN:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_STORE_DEN,  SEQ_NEXT,     UA_FIN);
      UA_FIN:    w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_DONE,     UA_FIN);
      UA_ERR:    w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_ERROR,      SEQ_JUMP,     UA_FIN);
      UA_UNARY:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_UNARY,      SEQ_JUMP,     UA_FIN);
      UA_CMP_0:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_CMP_1:  w = mk(MA_BN, MB_AD, ACC_X_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_CMP_2:  w = mk(MA_AN, MB_BD, ACC_Y_LOAD, ACT_NONE,       SEQ_NEXT,     UA_FIN);
      UA_CMP_3:  w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_COMPARE,    SEQ_JUMP,     UA_FIN);
      default:   w = mk(MA_AN, MB_BD, ACC_NONE,   ACT_NONE,       SEQ_JUMP,     UA_FIN);
    endcase
    return w;
  endfunction

  // dispatch: first micro-instruction of each operation
  function automatic upc_t entry_addr(op_t op);
    upc_t a;
    unique case (op)
      OP_ADD:  a = UA_ADD_0;
      OP_SUB:  a = UA_SUB_0;
      OP_MUL:  a = UA_MUL_0;
      OP_DIV:  a = UA_DIV_0;
      OP_NEG:  a = UA_UNARY;
      OP_INC:  a = UA_UNARY;
      OP_DEC:  a = UA_UNARY;
      OP_CMP:  a = UA_CMP_0;
      default: a = UA_FIN;
    endcase
    return a;
  endfunction

endpackage

// File: design/rau_in_if.sv
// request channel of the rational arithmetic unit: valid/ready plus operands
// depends on rau_pkg
interface rau_in_if;
  logic                                      valid;
  logic                                      ready;
  logic        [rau_pkg::OP_W-1:0]           operation;
  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_numerator;
  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  a_denominator;
  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_numerator;
  logic signed [rau_pkg::OPERAND_WIDTH-1:0]  b_denominator;

  modport source (
    output valid, operation, a_numerator, a_denominator, b_numerator, b_denominator,
    input  ready
  );
  modport sink (
    input  valid, operation, a_numerator, a_denominator, b_numerator, b_denominator,
    output ready
  );
endinterface

// File: design/rau_out_if.sv
// result channel of the rational arithmetic unit: valid/ready plus result fields
// depends on rau_pkg
interface rau_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rau_pkg::RESULT_W-1:0]  result_numerator;
  logic signed [rau_pkg::RESULT_W-1:0]  result_denominator;
  logic                                 is_less;
  logic                                 is_equal;
  logic                                 is_greater;
  logic                                 error;

  modport source (
    output valid, result_numerator, result_denominator, is_less, is_equal, is_greater,
           error,
    input  ready
  );
  modport sink (
    input  valid, result_numerator, result_denominator, is_less, is_equal, is_greater,
           error,
    output ready
  );
endinterface

// File: design/rational_arithmetic_unit_core.sv
// rational arithmetic unit, one request at a time under a microcoded sequencer
// add/sub/mul/div reduce their result by a binary gcd, one subtract or shift per
// iteration; compare and negate/inc/dec skip the gcd
// the next request is taken only once the sequencer has finished the last one, and may be taken while a result waits
// reset: synchronous active-low rst_n clears the sequencer and the result valid
// depends on rau_pkg, rau_in_if, rau_out_if
module rational_arithmetic_unit_core (
  input  logic     clk,
  input  logic     rst_n,
  rau_in_if.sink   in_chan,
  rau_out_if.source out_chan
);
  import rau_pkg::*;

  // sequencer
  logic   busy_r, busy_nxt;
  upc_t   upc_r, upc_nxt;
  uword_t uw;
  logic   finish;
  logic   in_accept;
  logic   out_free;

  // operands
  op_t                          op_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;

  // multiplier and cross-product accumulators
  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]        prod_nxt, prod_r;
  logic signed [RESULT_W-1:0]      prod_ext;
  logic signed [RESULT_W-1:0]      x_r, y_r;

  // binary gcd
  logic [MAG_W-1:0]   p_r, q_r, g_r, p_nxt, q_nxt, g_fin;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  logic               gcd_done;
  logic [RESULT_W-1:0] x_neg, y_neg;
  logic [MAG_W-1:0]   x_mag, y_mag;

  // restoring divider, one quotient bit per step
  logic [MAG_W-1:0]   dq_r, rem_r, dq_nxt, rem_nxt;
  logic [SHIFT_W-1:0] cnt_r;
  logic [MAG_W:0]     div_shift, div_diff;
  logic               div_ge;
  logic               div_last;
  logic signed [RESULT_W-1:0] quo_pos, quo_signed;

  // unary ops and compare
  logic signed [RESULT_W-1:0] an_ext, ad_ext, unary_num;
  logic                       cmp_flip;

  // working result and output register
  logic signed [RESULT_W-1:0] num_r, den_r;
  logic                       lt_r, eq_r, gt_r, err_r;
  logic                       ov_r;
  logic signed [RESULT_W-1:0] onum_r, oden_r;
  logic                       olt_r, oeq_r, ogt_r, oerr_r;

  // handshakes: a new request is taken whenever the sequencer is idle
  assign in_chan.ready = !busy_r;
  assign in_accept     = in_chan.valid && !busy_r;
  assign out_free      = !ov_r || out_chan.ready;

  // current micro-instruction
  assign uw = ucode(upc_r);

  // conditions tested by the sequencer
  assign gcd_done = (p_r == '0) || (q_r == '0);
  assign div_last = (cnt_r == SHIFT_W'(MAG_W - 1));

  // next micro-address
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    finish   = 1'b0;
    if (!busy_r) begin
      if (in_accept) begin
        busy_nxt = 1'b1;
        upc_nxt  = entry_addr(op_t'(in_chan.operation));
      end
    end else begin
      unique case (uw.seq)
        SEQ_NEXT:     upc_nxt = upc_r + upc_t'(1);
        SEQ_JUMP:     upc_nxt = uw.target;
        SEQ_GCD_LOOP: upc_nxt = gcd_done ? upc_r + upc_t'(1) : upc_r;
        SEQ_DIV_LOOP: upc_nxt = div_last ? upc_r + upc_t'(1) : upc_r;
        SEQ_GZERO:    upc_nxt = (g_r == '0) ? uw.target : upc_r + upc_t'(1);
        SEQ_DONE: begin
          // hold here until the output register is free
          if (out_free) begin
            busy_nxt = 1'b0;
            finish   = 1'b1;
          end
        end
        default:      upc_nxt = UA_FIN;
      endcase
    end
  end

  // multiplier operand steering from the control word
  always_comb begin
    unique case (uw.ma)
      MA_AN:   mul_a = an_r;
      MA_AD:   mul_a = ad_r;
      MA_BN:   mul_a = bn_r;
      default: mul_a = an_r;
    endcase
    unique case (uw.mb)
      MB_BD:   mul_b = bd_r;
      MB_BN:   mul_b = bn_r;
      MB_AD:   mul_b = ad_r;
      default: mul_b = bd_r;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = {prod_r[PROD_W-1], prod_r};

  // magnitudes of the cross products
  assign x_neg = -x_r;
  assign y_neg = -y_r;
  assign x_mag = x_r[RESULT_W-1] ? x_neg[MAG_W-1:0] : x_r[MAG_W-1:0];
  assign y_mag = y_r[RESULT_W-1] ? y_neg[MAG_W-1:0] : y_r[MAG_W-1:0];

  // one binary gcd step: strip shared twos, strip lone twos, else subtract smaller
  always_comb begin
    p_nxt = p_r;
    q_nxt = q_r;
    k_nxt = k_r;
    priority if (!p_r[0] && !q_r[0]) begin
      p_nxt = p_r >> 1;
      q_nxt = q_r >> 1;
      k_nxt = k_r + SHIFT_W'(1);
    end else if (!p_r[0]) begin
      p_nxt = p_r >> 1;
    end else if (!q_r[0]) begin
      q_nxt = q_r >> 1;
    end else if (p_r >= q_r) begin
      p_nxt = p_r - q_r;
    end else begin
      q_nxt = q_r - p_r;
    end
  end

  // one of p, q is zero here, so the or picks the other
  assign g_fin = (p_r | q_r) << k_r;

  // divider step
  assign div_shift = {rem_r, dq_r[MAG_W-1]};
  assign div_ge    = div_shift >= {1'b0, g_r};
  assign div_diff  = div_shift - {1'b0, g_r};
  assign rem_nxt   = div_ge ? div_diff[MAG_W-1:0] : div_shift[MAG_W-1:0];
  assign dq_nxt    = {dq_r[MAG_W-2:0], div_ge};

  // quotient gets the sign of the part it came from
  assign quo_pos    = {1'b0, dq_r};
  assign quo_signed = (uw.act == ACT_STORE_NUM) ? (x_r[RESULT_W-1] ? -quo_pos : quo_pos)
                                                : (y_r[RESULT_W-1] ? -quo_pos : quo_pos);

  // negate, increment, decrement of a
  assign an_ext = {{(RESULT_W-OPERAND_WIDTH){an_r[OPERAND_WIDTH-1]}}, an_r};
  assign ad_ext = {{(RESULT_W-OPERAND_WIDTH){ad_r[OPERAND_WIDTH-1]}}, ad_r};
  always_comb begin
    unique case (op_r)
      OP_NEG:  unary_num = -an_ext;
      OP_INC:  unary_num = an_ext + ad_ext;
      OP_DEC:  unary_num = an_ext - ad_ext;
      default: unary_num = an_ext;
    endcase
  end

  // a negative denominator on exactly one side reverses the cross-product order
  assign cmp_flip = ad_r[OPERAND_WIDTH-1] ^ bd_r[OPERAND_WIDTH-1];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UA_FIN;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      if (finish) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= op_t'(in_chan.operation);
      an_r  <= in_chan.a_numerator;
      ad_r  <= in_chan.a_denominator;
      bn_r  <= in_chan.b_numerator;
      bd_r  <= in_chan.b_denominator;
      num_r <= '0;
      den_r <= '0;
      lt_r  <= 1'b0;
      eq_r  <= 1'b0;
      gt_r  <= 1'b0;
      err_r <= 1'b0;
    end
    if (busy_r) begin
      prod_r <= prod_nxt;
      unique case (uw.acc)
        ACC_X_LOAD: x_r <= prod_ext;
        ACC_X_ADD:  x_r <= x_r + prod_ext;
        ACC_X_SUB:  x_r <= x_r - prod_ext;
        ACC_Y_LOAD: y_r <= prod_ext;
        default: ;
      endcase
      unique case (uw.act)
        ACT_GCD_INIT: begin
          p_r <= x_mag;
          q_r <= y_mag;
          k_r <= '0;
        end
        ACT_GCD_STEP: begin
          if (!gcd_done) begin
            p_r <= p_nxt;
            q_r <= q_nxt;
            k_r <= k_nxt;
          end
        end
        ACT_GCD_FIN:  g_r <= g_fin;
        ACT_DIV_LOAD_X: begin
          dq_r  <= x_mag;
          rem_r <= '0;
          cnt_r <= '0;
        end
        ACT_DIV_LOAD_Y: begin
          dq_r  <= y_mag;
          rem_r <= '0;
          cnt_r <= '0;
        end
        ACT_DIV_STEP: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + SHIFT_W'(1);
        end
        ACT_STORE_NUM: num_r <= quo_signed;
        ACT_STORE_DEN: den_r <= quo_signed;
        ACT_UNARY: begin
          num_r <= unary_num;
          den_r <= ad_ext;
        end
        ACT_COMPARE: begin
          if (ad_r == '0 || bd_r == '0) begin
            err_r <= 1'b1;
          end else if (x_r == y_r) begin
            eq_r <= 1'b1;
          end else if ((x_r < y_r) != cmp_flip) begin
            lt_r <= 1'b1;
          end else begin
            gt_r <= 1'b1;
          end
        end
        ACT_ERROR:    err_r <= 1'b1;
        default: ;
      endcase
    end
    if (finish) begin
      onum_r <= num_r;
      oden_r <= den_r;
      olt_r  <= lt_r;
      oeq_r  <= eq_r;
      ogt_r  <= gt_r;
      oerr_r <= err_r;
    end
  end

  assign out_chan.valid              = ov_r;
  assign out_chan.result_numerator   = onum_r;
  assign out_chan.result_denominator = oden_r;
  assign out_chan.is_less            = olt_r;
  assign out_chan.is_equal           = oeq_r;
  assign out_chan.is_greater         = ogt_r;
  assign out_chan.error              = oerr_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for rational_arithmetic_unit_core: directed and random fraction
// requests, each result checked against a predictor of the unit
// depends on rau_pkg, rau_in_if, rau_out_if and the rtl of the unit
module tb_top;
  import rau_pkg::*;

  // one request: operation plus the two fractions a and b
  typedef struct {
    op_t                              operation;
    logic signed [OPERAND_WIDTH-1:0]  a_num;
    logic signed [OPERAND_WIDTH-1:0]  a_den;
    logic signed [OPERAND_WIDTH-1:0]  b_num;
    logic signed [OPERAND_WIDTH-1:0]  b_den;
  } fraction_pair_t;

  // one result as it should leave the unit
  typedef struct {
    logic [RESULT_W-1:0] num;
    logic [RESULT_W-1:0] den;
    logic                less;
    logic                equal;
    logic                greater;
    logic                err;
  } fraction_result_t;

  logic clk;
  logic rst_n;

  rau_in_if  in_chan ();
  rau_out_if out_chan ();

  rational_arithmetic_unit_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // results still owed by the unit, oldest first
  fraction_result_t fractions_due[$];
  int               mismatch_count;

  // idle rates in percent, and a request for a long receiver hold-off
  int sender_idle_pct;
  int receiver_idle_pct;
  int receiver_hold;

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop in case the unit hangs
  initial begin
    #40_000_000;
    $display("rational_arithmetic_unit_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor of the whole unit
  // ---------------------------------------------------------------------------
  function automatic fraction_result_t rational_alu(fraction_pair_t q);
    fraction_result_t r;
    longint           an, ad, bn, bd;
    longint           x, y, lhs, rhs, qn, qd;
    longint unsigned  mag_x, mag_y, gp, gq, gt;
    logic             flip;
    r  = '{default: '0};
    an = q.a_num;
    ad = q.a_den;
    bn = q.b_num;
    bd = q.b_den;
    x  = 0;
    y  = 0;
    case (q.operation)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        // cross products, at most 2^31 in magnitude so no wrap in 64 bits
        case (q.operation)
          OP_ADD: begin
            x = an * bd + bn * ad;
            y = ad * bd;
          end
          OP_SUB: begin
            x = an * bd - bn * ad;
            y = ad * bd;
          end
          OP_MUL: begin
            x = an * bn;
            y = ad * bd;
          end
          default: begin
            x = an * bd;
            y = ad * bn;
          end
        endcase
        mag_x = (x < 0) ? -x : x;
        mag_y = (y < 0) ? -y : y;
        // euclid on the magnitudes
        gp = mag_x;
        gq = mag_y;
        while (gq != 0) begin
          gt = gp % gq;
          gp = gq;
          gq = gt;
        end
        if (gp == 0) begin
          // both parts zero: no divisor exists
          r.err = 1'b1;
        end else begin
          // each part keeps the sign of its own product
          qn = longint'(mag_x / gp);
          qd = longint'(mag_y / gp);
          if (x < 0) qn = -qn;
          if (y < 0) qd = -qd;
          r.num = qn[RESULT_W-1:0];
          r.den = qd[RESULT_W-1:0];
        end
      end
      OP_NEG, OP_INC, OP_DEC: begin
        // a alone, no reduction
        case (q.operation)
          OP_NEG:  qn = -an;
          OP_INC:  qn = an + ad;
          default: qn = an - ad;
        endcase
        r.num = qn[RESULT_W-1:0];
        r.den = ad[RESULT_W-1:0];
      end
      default: begin
        // exact compare, the ordering flips when exactly one denominator is negative
        if (ad == 0 || bd == 0) begin
          r.err = 1'b1;
        end else begin
          lhs  = an * bd;
          rhs  = bn * ad;
          flip = (ad < 0) != (bd < 0);
          if (lhs == rhs) r.equal = 1'b1;
          else if ((lhs < rhs) != flip) r.less = 1'b1;
          else r.greater = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic fraction_pair_t make_pair(op_t op, int an, int ad, int bn, int bd);
    fraction_pair_t p;
    p.operation = op;
    p.a_num     = an[OPERAND_WIDTH-1:0];
    p.a_den     = ad[OPERAND_WIDTH-1:0];
    p.b_num     = bn[OPERAND_WIDTH-1:0];
    p.b_den     = bd[OPERAND_WIDTH-1:0];
    return p;
  endfunction

  // operand mix: full range, small values, extremes, zero, and values with big common factors
  function automatic logic signed [OPERAND_WIDTH-1:0] random_operand();
    logic signed [OPERAND_WIDTH-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = OPERAND_WIDTH'($urandom);
      4, 5:       v = OPERAND_WIDTH'($urandom_range(16) - 8);
      6: begin
        case ($urandom_range(3))
          0:       v = OPERAND_WIDTH'(-32768);
          1:       v = OPERAND_WIDTH'(32767);
          2:       v = OPERAND_WIDTH'(-1);
          default: v = OPERAND_WIDTH'(1);
        endcase
      end
      7:          v = '0;
      8: begin
        v = OPERAND_WIDTH'($urandom_range(1, 60) * $urandom_range(1, 12));
        if ($urandom_range(1)) v = -v;
      end
      default:    v = OPERAND_WIDTH'($urandom) & 16'hff00;
    endcase
    return v;
  endfunction

  // offer one request, hold it until taken, then book its result
  // valid is left high so a back-to-back request needs no second assignment
  task automatic send_request(fraction_pair_t p);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= p.operation;
    in_chan.a_numerator   <= p.a_num;
    in_chan.a_denominator <= p.a_den;
    in_chan.b_numerator   <= p.b_num;
    in_chan.b_denominator <= p.b_den;
    do @(posedge clk); while (!in_chan.ready);
    fractions_due.push_back(rational_alu(p));
  endtask

  // sender goes quiet until every booked result has come back
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (fractions_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready, or a long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int stall_left;
    out_chan.ready = 1'b0;
    stall_left     = 0;
    forever begin
      @(posedge clk);
      if (receiver_hold > 0) begin
        stall_left    = receiver_hold;
        receiver_hold = 0;
      end
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest booked result
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, logic [RESULT_W-1:0] want,
                             logic [RESULT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d (0x%h) got %0d (0x%h)", $time, field,
               $signed(want), want, $signed(got), got);
    end
  endtask

  always @(posedge clk) begin : result_check
    fraction_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (fractions_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing outstanding, numerator %0d denominator %0d",
                 $time, out_chan.result_numerator, out_chan.result_denominator);
      end else begin
        want = fractions_due.pop_front();
        check_field("result_numerator", want.num, out_chan.result_numerator);
        check_field("result_denominator", want.den, out_chan.result_denominator);
        check_field("is_less", RESULT_W'(want.less), RESULT_W'(out_chan.is_less));
        check_field("is_equal", RESULT_W'(want.equal), RESULT_W'(out_chan.is_equal));
        check_field("is_greater", RESULT_W'(want.greater), RESULT_W'(out_chan.is_greater));
        check_field("error", RESULT_W'(want.err), RESULT_W'(out_chan.error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked requests: extremes, every operation, divisor zero, compare corners
  task automatic test_directed_cases();
    sender_idle_pct   = 6;
    receiver_idle_pct = 57;
    send_request(make_pair(OP_ADD, 1, 2, 1, 3));
    // largest sum of cross products, 2^31
    send_request(make_pair(OP_ADD, -32768, -32768, -32768, -32768));
    send_request(make_pair(OP_SUB, -32768, 32767, 32767, -32768));
    send_request(make_pair(OP_SUB, -32768, -32768, -32768, 32767));
    send_request(make_pair(OP_MUL, -32768, -32768, -32768, -32768));
    send_request(make_pair(OP_MUL, -3, 4, 5, -6));
    send_request(make_pair(OP_DIV, 32767, 1, -32768, 1));
    // division by a zero fraction leaves a zero denominator
    send_request(make_pair(OP_DIV, 3, 4, 0, 5));
    // both cross products zero: no gcd, error
    send_request(make_pair(OP_ADD, 0, 0, 5, 0));
    send_request(make_pair(OP_MUL, 0, 0, 3, 7));
    send_request(make_pair(OP_DIV, 0, 3, 0, 5));
    // zero numerator with a live denominator reduces to 0/1
    send_request(make_pair(OP_ADD, 1, 2, -1, 2));
    send_request(make_pair(OP_NEG, -32768, 5, 0, 0));
    send_request(make_pair(OP_NEG, 7, 0, 1, 1));
    send_request(make_pair(OP_INC, 32767, 32767, 0, 0));
    send_request(make_pair(OP_DEC, -32768, 32767, 0, 0));
    send_request(make_pair(OP_CMP, 1, 2, 2, 4));
    send_request(make_pair(OP_CMP, 1, -2, 1, 3));
    send_request(make_pair(OP_CMP, 1, 2, -1, -3));
    send_request(make_pair(OP_CMP, -1, -2, 1, 2));
    // compare with a zero denominator on either side
    send_request(make_pair(OP_CMP, 1, 0, 1, 2));
    send_request(make_pair(OP_CMP, 1, 2, 1, 0));
    send_request(make_pair(OP_CMP, -32768, 32767, 32767, -32768));
  endtask

  // random requests over all operations at the given idle rates
  task automatic test_random_mix(int count, int s_pct, int r_pct);
    fraction_pair_t p;
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    repeat (count) begin
      p.operation = op_t'($urandom_range(7));
      p.a_num     = random_operand();
      p.a_den     = random_operand();
      p.b_num     = random_operand();
      p.b_den     = random_operand();
      send_request(p);
    end
  endtask

  // receiver holds off long enough that a result waits, the next request is taken,
  // and the input then stalls while more requests are offered
  task automatic test_result_hold_off();
    sender_idle_pct = 0;
    receiver_hold   = 600;
    send_request(make_pair(OP_NEG, 5, 9, 0, 1));
    send_request(make_pair(OP_CMP, 3, 4, 5, 6));
    send_request(make_pair(OP_INC, -7, 3, 0, 1));
    send_request(make_pair(OP_ADD, 10, 12, 14, 16));
    send_request(make_pair(OP_DEC, 100, -3, 0, 1));
    send_request(make_pair(OP_MUL, 96, 64, 48, 40));
    send_request(make_pair(OP_CMP, -9, 2, 9, -2));
    send_request(make_pair(OP_DIV, 1000, 300, 250, 75));
    // sender pauses until every result is back
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count        = 0;
    sender_idle_pct       = 0;
    receiver_idle_pct     = 0;
    receiver_hold         = 0;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.operation     = '0;
    in_chan.a_numerator   = '0;
    in_chan.a_denominator = '0;
    in_chan.b_numerator   = '0;
    in_chan.b_denominator = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_mix(520, 6, 57);
    test_result_hold_off();
    test_random_mix(520, 57, 6);
    test_random_mix(540, 0, 0);

    // all requests taken: wait out the results, then the worst-case latency
    wait_results_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rational_arithmetic_unit_core verification clean");
    end else begin
      $display("rational_arithmetic_unit_core verification failed");
    end
    $finish;
  end

endmodule

// File: rational_arithmetic_unit_core.f
design/rau_pkg.sv
design/rau_in_if.sv
design/rau_out_if.sv
design/rational_arithmetic_unit_core.sv
tb/tb_top.sv
